FILE: src/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

    localparam int HUE_W  = 16;
    localparam int HR_W   = 15;   // reduced hue, below 23040
    localparam int SEC_W  = 3;
    localparam int REM_W  = 12;   // remainder within a sector, below 3840
    localparam int FIX_W  = 9;
    localparam int TERM_W = 20;   // term numerators, up to 256*3840
    localparam int PROD_W = FIX_W + TERM_W;
    localparam int SCL_W  = PROD_W + 5;
    localparam int CHAN_W = 8;

    localparam logic [HUE_W-1:0]  HUE_FULL_TURN = 16'd23040;
    localparam logic [HUE_W-1:0]  HUE_TWO_TURNS = 16'd46080;
    localparam logic [REM_W-1:0]  HUE_SECTOR    = 12'd3840;
    localparam logic [FIX_W-1:0]  FIX_ONE       = 9'd256;
    localparam logic [TERM_W-1:0] TERM_ONE      = 20'd983040;

    // 255 / (256*256*3840) reduces to 17 / 2^24
    localparam int CHAN_SHIFT = 24;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [FIX_W-1:0] saturation;
        logic [FIX_W-1:0] brightness;
    } hsv_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } chan_t;

    typedef enum logic [1:0] {
        TERM_V = 2'd0,
        TERM_P = 2'd1,
        TERM_Q = 2'd2,
        TERM_T = 2'd3
    } term_t;

    localparam logic [SEC_W-1:0] SEC_0 = 3'd0;
    localparam logic [SEC_W-1:0] SEC_1 = 3'd1;
    localparam logic [SEC_W-1:0] SEC_2 = 3'd2;
    localparam logic [SEC_W-1:0] SEC_3 = 3'd3;
    localparam logic [SEC_W-1:0] SEC_4 = 3'd4;
    localparam logic [SEC_W-1:0] SEC_5 = 3'd5;

    typedef struct packed {
        logic prod;
        logic scale;
    } stage_en_t;

    function automatic term_t term_sel(input logic [SEC_W-1:0] sector, input chan_t ch);
        term_t r, g, b;
        case (sector)
            SEC_0:   begin r = TERM_V; g = TERM_T; b = TERM_P; end
            SEC_1:   begin r = TERM_Q; g = TERM_V; b = TERM_P; end
            SEC_2:   begin r = TERM_P; g = TERM_V; b = TERM_T; end
            SEC_3:   begin r = TERM_P; g = TERM_Q; b = TERM_V; end
            SEC_4:   begin r = TERM_T; g = TERM_P; b = TERM_V; end
            default: begin r = TERM_V; g = TERM_P; b = TERM_Q; end
        endcase
        case (ch)
            CH_RED:   return r;
            CH_GREEN: return g;
            default:  return b;
        endcase
    endfunction

endpackage

FILE: src/hsv2rgb_chan.sv
module hsv2rgb_chan #(
    parameter hsv2rgb_pkg::chan_t CHAN = hsv2rgb_pkg::CH_RED
) (
    input  logic                                clk,
    input  hsv2rgb_pkg::stage_en_t              en,
    input  logic [hsv2rgb_pkg::SEC_W-1:0]       sector,
    input  logic [hsv2rgb_pkg::FIX_W-1:0]       val,
    input  logic [hsv2rgb_pkg::TERM_W-1:0]      xp,
    input  logic [hsv2rgb_pkg::TERM_W-1:0]      xq,
    input  logic [hsv2rgb_pkg::TERM_W-1:0]      xt,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]      chan
);

    logic [hsv2rgb_pkg::TERM_W-1:0] term;
    logic [hsv2rgb_pkg::PROD_W-1:0] prod_next;
    logic [hsv2rgb_pkg::PROD_W-1:0] prod_reg;
    logic [hsv2rgb_pkg::SCL_W-1:0]  scaled;
    logic [hsv2rgb_pkg::CHAN_W-1:0] chan_next;
    logic [hsv2rgb_pkg::CHAN_W-1:0] chan_reg;

    always_comb
    begin
        case (hsv2rgb_pkg::term_sel(sector, CHAN))
            hsv2rgb_pkg::TERM_P: term = xp;
            hsv2rgb_pkg::TERM_Q: term = xq;
            hsv2rgb_pkg::TERM_T: term = xt;
            default:             term = hsv2rgb_pkg::TERM_ONE;
        endcase
        prod_next = hsv2rgb_pkg::PROD_W'(val) * hsv2rgb_pkg::PROD_W'(term);
    end

    // times 17, then drop 24 bits
    always_comb
    begin
        scaled    = {1'b0, prod_reg, 4'b0000} + hsv2rgb_pkg::SCL_W'(prod_reg);
        chan_next = scaled[hsv2rgb_pkg::CHAN_SHIFT +: hsv2rgb_pkg::CHAN_W];
    end

    always_ff @(posedge clk)
    begin
        if (en.prod)
        begin
            prod_reg <= prod_next;
        end
        if (en.scale)
        begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

FILE: src/hsv_to_rgb_converter.sv
// HSV to RGB converter, six-sector scheme. Hue is in 1/64 degree units and is
// taken modulo 360 degrees; saturation and brightness use 256 as 1.0, and
// larger codes clip to 1.0. Each channel is floor(255 * term) with the terms
// formed exactly. The block is a five-stage pipeline (hue reduction, sector
// split, term numerators, per-channel multiply, scale to 8 bits): it accepts
// one color every clock while the output side does not stall, and rgb_valid
// is the valid flag of the last stage, which holds the result. Stalls hold
// data in place and empty stages fill up, so a waiting result never blocks
// input until the pipe is full.
module hsv_to_rgb_converter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              hsv_valid,
    output logic              hsv_ready,
    input  hsv2rgb_pkg::hsv_t hsv,
    output logic              rgb_valid,
    input  logic              rgb_ready,
    output hsv2rgb_pkg::rgb_t rgb
);

    localparam int STAGES = 5;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES:0]   en;

    // stage 1: clip and reduce hue
    logic [hsv2rgb_pkg::HUE_W-1:0] hr_full;
    logic [hsv2rgb_pkg::HR_W-1:0]  hr1_next, hr1_reg;
    logic [hsv2rgb_pkg::FIX_W-1:0] sat1_next, sat1_reg, val1_reg, val1_next;

    // stage 2: sector and remainder
    logic [hsv2rgb_pkg::SEC_W-1:0] sec2_next, sec2_reg;
    logic [hsv2rgb_pkg::HR_W-1:0]  base2;
    logic [hsv2rgb_pkg::REM_W-1:0] rem2_next, rem2_reg;
    logic [hsv2rgb_pkg::FIX_W-1:0] sat2_reg, val2_reg;

    // stage 3: term numerators
    logic [hsv2rgb_pkg::TERM_W:0]   sr_q, sr_t, sp;
    logic [hsv2rgb_pkg::REM_W-1:0]  rem_c;
    logic [hsv2rgb_pkg::FIX_W-1:0]  sat_c;
    logic [hsv2rgb_pkg::TERM_W-1:0] xp3_next, xq3_next, xt3_next;
    logic [hsv2rgb_pkg::TERM_W-1:0] xp3_reg, xq3_reg, xt3_reg;
    logic [hsv2rgb_pkg::SEC_W-1:0]  sec3_reg;
    logic [hsv2rgb_pkg::FIX_W-1:0]  val3_reg;

    hsv2rgb_pkg::stage_en_t chan_en;

    // per-stage enable: a stage loads when empty or when the next one moves
    always_comb
    begin
        en[STAGES] = rgb_ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next[0] = en[0] ? hsv_valid : vld_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            if (en[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
            else
            begin
                vld_next[k] = vld_reg[k];
            end
        end
    end

    assign hsv_ready = en[0];
    assign rgb_valid = vld_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        sat1_next = (hsv.saturation > hsv2rgb_pkg::FIX_ONE) ? hsv2rgb_pkg::FIX_ONE
                                                            : hsv.saturation;
        val1_next = (hsv.brightness > hsv2rgb_pkg::FIX_ONE) ? hsv2rgb_pkg::FIX_ONE
                                                            : hsv.brightness;
        if (hsv.hue >= hsv2rgb_pkg::HUE_TWO_TURNS)
        begin
            hr_full = hsv.hue - hsv2rgb_pkg::HUE_TWO_TURNS;
        end
        else if (hsv.hue >= hsv2rgb_pkg::HUE_FULL_TURN)
        begin
            hr_full = hsv.hue - hsv2rgb_pkg::HUE_FULL_TURN;
        end
        else
        begin
            hr_full = hsv.hue;
        end
        hr1_next = hr_full[hsv2rgb_pkg::HR_W-1:0];
    end

    always_comb
    begin
        sec2_next = hsv2rgb_pkg::SEC_0;
        base2     = '0;
        for (int k = 1; k < 6; k++)
        begin
            if (hr1_reg >= hsv2rgb_pkg::HR_W'(k * 3840))
            begin
                sec2_next = hsv2rgb_pkg::SEC_W'(k);
                base2     = hsv2rgb_pkg::HR_W'(k * 3840);
            end
        end
        rem2_next = hsv2rgb_pkg::REM_W'(hr1_reg - base2);
    end

    always_comb
    begin
        rem_c    = hsv2rgb_pkg::HUE_SECTOR - rem2_reg;
        sat_c    = hsv2rgb_pkg::FIX_ONE - sat2_reg;
        sr_q     = (hsv2rgb_pkg::TERM_W+1)'(sat2_reg) * (hsv2rgb_pkg::TERM_W+1)'(rem2_reg);
        sr_t     = (hsv2rgb_pkg::TERM_W+1)'(sat2_reg) * (hsv2rgb_pkg::TERM_W+1)'(rem_c);
        sp       = (hsv2rgb_pkg::TERM_W+1)'(sat_c)
                   * (hsv2rgb_pkg::TERM_W+1)'(hsv2rgb_pkg::HUE_SECTOR);
        xq3_next = hsv2rgb_pkg::TERM_ONE - sr_q[hsv2rgb_pkg::TERM_W-1:0];
        xt3_next = hsv2rgb_pkg::TERM_ONE - sr_t[hsv2rgb_pkg::TERM_W-1:0];
        xp3_next = sp[hsv2rgb_pkg::TERM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            hr1_reg  <= hr1_next;
            sat1_reg <= sat1_next;
            val1_reg <= val1_next;
        end
        if (en[1])
        begin
            sec2_reg <= sec2_next;
            rem2_reg <= rem2_next;
            sat2_reg <= sat1_reg;
            val2_reg <= val1_reg;
        end
        if (en[2])
        begin
            xp3_reg  <= xp3_next;
            xq3_reg  <= xq3_next;
            xt3_reg  <= xt3_next;
            sec3_reg <= sec2_reg;
            val3_reg <= val2_reg;
        end
    end

    assign chan_en.prod  = en[3];
    assign chan_en.scale = en[4];

    hsv2rgb_chan #(.CHAN(hsv2rgb_pkg::CH_RED)) u_red (
        .clk    (clk),
        .en     (chan_en),
        .sector (sec3_reg),
        .val    (val3_reg),
        .xp     (xp3_reg),
        .xq     (xq3_reg),
        .xt     (xt3_reg),
        .chan   (rgb.red)
    );

    hsv2rgb_chan #(.CHAN(hsv2rgb_pkg::CH_GREEN)) u_green (
        .clk    (clk),
        .en     (chan_en),
        .sector (sec3_reg),
        .val    (val3_reg),
        .xp     (xp3_reg),
        .xq     (xq3_reg),
        .xt     (xt3_reg),
        .chan   (rgb.green)
    );

    hsv2rgb_chan #(.CHAN(hsv2rgb_pkg::CH_BLUE)) u_blue (
        .clk    (clk),
        .en     (chan_en),
        .sector (sec3_reg),
        .val    (val3_reg),
        .xp     (xp3_reg),
        .xq     (xq3_reg),
        .xt     (xt3_reg),
        .chan   (rgb.blue)
    );

`ifndef ASSERT_OFF
    a_hue_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> (hsv2rgb_pkg::HUE_W'(hr1_reg) < hsv2rgb_pkg::HUE_FULL_TURN))
        else $error("reduced hue out of range");

    a_sector_split: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[1] |-> (rem2_reg < hsv2rgb_pkg::HUE_SECTOR) && (sec2_reg <= hsv2rgb_pkg::SEC_5))
        else $error("sector or remainder out of range");

    a_terms_sum: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> ((hsv2rgb_pkg::TERM_W+1)'(xq3_reg) + (hsv2rgb_pkg::TERM_W+1)'(xt3_reg)
                        == (hsv2rgb_pkg::TERM_W+1)'(hsv2rgb_pkg::TERM_ONE)
                           + (hsv2rgb_pkg::TERM_W+1)'(xp3_reg)))
        else $error("q + t differs from one + p");

    a_p_smallest: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> (xp3_reg <= xq3_reg) && (xp3_reg <= xt3_reg))
        else $error("p term exceeds q or t");
`endif

endmodule
